>>> design/blcp_pkg.sv
// ----------------------------------------------------------------------------
// blcp_pkg
// Shared constants, types and helper functions of the box LCP solver.
// ----------------------------------------------------------------------------
package blcp_pkg;

    // Sizes
    localparam int MAX_VARS      = 32;
    localparam int FRACTION_BITS = 32;
    localparam int DATA_W        = 48;
    localparam int IDX_W         = 5;
    localparam int N_W           = 6;
    localparam int MAT_AW        = 10;
    localparam int MAT_DEPTH     = 1024;
    localparam int ACC_W         = 54;
    localparam int PROD_W        = 96;
    localparam int MSLICE_W      = 16;
    localparam int MSTEPS        = 3;
    localparam int DVD_W         = DATA_W + FRACTION_BITS;
    localparam int DIV_CW        = 7;
    localparam int SWEEP_W       = 16;
    localparam int RES_W         = 47;
    localparam int CFG_AW        = 5;
    localparam int CFG_DW        = 64;

    // Fixed-point extremes
    localparam logic signed [DATA_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic [DATA_W:0]          CAP49 = 49'h1_0000_0000_0000;
    localparam logic [DATA_W:0]          HALF_RANGE = 49'h0_8000_0000_0000;

    // Item modes
    localparam logic [2:0] MODE_MATRIX = 3'd0;
    localparam logic [2:0] MODE_OFFSET = 3'd1;
    localparam logic [2:0] MODE_BOUNDS = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_SOLVE  = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_ITER = 2'd1;
    localparam logic [1:0] REG_TOL  = 2'd2;

    // Register resets and defaults
    localparam logic [N_W-1:0]     SIZE_RESET    = 6'd32;
    localparam logic [SWEEP_W-1:0] ITER_RESET    = 16'd100;
    localparam logic [SWEEP_W-1:0] DEFAULT_ITERS = 16'd100;
    localparam logic [RES_W-1:0]   TOL_RESET     = 47'd4295;
    localparam logic [RES_W-1:0]   DEFAULT_TOL   = 47'd4295;

    // Controller to datapath commands
    typedef struct packed {
        logic               mem_we;
        logic               mem_zero;
        logic [MAT_AW-1:0]  mem_addr;
        logic [IDX_W-1:0]   vaddr;
        logic               ld_q;
        logic               ld_bnd;
        logic               ld_lam;
        logic               row_start;
        logic               diag_latch;
        logic               term_y;
        logic               term_x;
        logic               mul_step;
        logic [1:0]         mul_idx;
        logic               rnd;
        logic               acc_add;
        logic               w_latch;
        logic               div_start;
        logic               upd;
        logic               delta_max;
        logic               sweep_clr;
        logic               res_clr;
        logic               res_upd;
        logic               out_load;
        logic               out_last;
        logic [SWEEP_W-1:0] sweeps;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic diag_pos;
        logic div_done;
        logic converged;
        logic out_free;
    } stat_t;

    // Attach sign to a magnitude and saturate to 48 bits
    function automatic logic signed [DATA_W-1:0] apply_sign(input logic [DATA_W:0] m,
                                                            input logic neg);
        logic [DATA_W-1:0] low;
        low = m[DATA_W-1:0];
        if (neg)
        begin
            apply_sign = (m >= HALF_RANGE) ? MIN48 : $signed(-low);
        end
        else
        begin
            apply_sign = (m >= HALF_RANGE) ? MAX48 : $signed(low);
        end
    endfunction

endpackage

>>> design/blcp_if.sv
// ----------------------------------------------------------------------------
// blcp_if
// Valid/ready channels of the box LCP solver: load/solve items and results.
// ----------------------------------------------------------------------------
interface blcp_item_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          mode;
    logic [blcp_pkg::IDX_W-1:0]          row;
    logic [blcp_pkg::IDX_W-1:0]          col;
    logic signed [blcp_pkg::DATA_W-1:0]  value;
    logic signed [blcp_pkg::DATA_W-1:0]  second_value;

    modport source (output valid, mode, row, col, value, second_value, input ready);
    modport sink   (input valid, mode, row, col, value, second_value, output ready);
endinterface

interface blcp_result_if;
    logic                                valid;
    logic                                ready;
    logic [blcp_pkg::IDX_W-1:0]          index;
    logic signed [blcp_pkg::DATA_W-1:0]  solution;
    logic [blcp_pkg::SWEEP_W-1:0]        sweeps_done;
    logic [blcp_pkg::RES_W-1:0]          residual;
    logic                                last;

    modport source (output valid, index, solution, sweeps_done, residual, last, input ready);
    modport sink   (input valid, index, solution, sweeps_done, residual, last, output ready);
endinterface

>>> design/blcp_div.sv
// ----------------------------------------------------------------------------
// blcp_div
// Restoring divider, one quotient bit per cycle: num * 2^F / den, rounded
// half away from zero, signed and saturated to 48 bits.
// ----------------------------------------------------------------------------
module blcp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [blcp_pkg::DATA_W-1:0]         num_mag,
    input  logic [blcp_pkg::DATA_W-1:0]         den,
    input  logic                                neg,
    output logic                                done,
    output logic signed [blcp_pkg::DATA_W-1:0]  quot
);

    logic                               busy_reg, busy_next;
    logic                               fin_reg, fin_next;
    logic                               done_reg, done_next;
    logic [blcp_pkg::DIV_CW-1:0]        cnt_reg;
    logic [blcp_pkg::DVD_W-1:0]         dvd_reg;
    logic [blcp_pkg::DATA_W:0]          rem_reg;
    logic [blcp_pkg::DVD_W-1:0]         quo_reg;
    logic [blcp_pkg::DATA_W-1:0]        den_reg;
    logic                               neg_reg;
    logic signed [blcp_pkg::DATA_W-1:0] quot_reg;

    logic [blcp_pkg::DATA_W:0]   trial;
    logic                        ge;
    logic                        round_up;
    logic [blcp_pkg::DVD_W:0]    q_round;
    logic [blcp_pkg::DATA_W:0]   q_cap;

    // one trial subtraction
    assign trial = {rem_reg[blcp_pkg::DATA_W-1:0], dvd_reg[blcp_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // rounding and saturation of the finished quotient
    assign round_up = {rem_reg, 1'b0} >= {2'b00, den_reg};
    assign q_round  = {1'b0, quo_reg} + {{blcp_pkg::DVD_W{1'b0}}, round_up};
    assign q_cap    = (q_round > {{(blcp_pkg::DVD_W - blcp_pkg::DATA_W){1'b0}},
                                  blcp_pkg::CAP49})
                      ? blcp_pkg::CAP49 : q_round[blcp_pkg::DATA_W:0];

    // control flags
    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == blcp_pkg::DIV_CW'(blcp_pkg::DVD_W - 1))
        begin
            busy_next = 1'b0;
            fin_next  = 1'b1;
        end
        if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    // shift and subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num_mag, {blcp_pkg::FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[blcp_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[blcp_pkg::DVD_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (fin_reg)
        begin
            quot_reg <= blcp_pkg::apply_sign(q_cap, neg_reg);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> design/blcp_datapath.sv
// ----------------------------------------------------------------------------
// blcp_datapath
// Storage (matrix memory, vectors), sliced multiplier, accumulator, divider,
// projection, convergence and residual tracking, and the result register.
// ----------------------------------------------------------------------------
module blcp_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  blcp_pkg::cmd_t                      cmd,
    output blcp_pkg::stat_t                     stat,
    input  logic signed [blcp_pkg::DATA_W-1:0]  value,
    input  logic signed [blcp_pkg::DATA_W-1:0]  second_value,
    input  logic [blcp_pkg::RES_W-1:0]          tol,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [blcp_pkg::IDX_W-1:0]          out_index,
    output logic signed [blcp_pkg::DATA_W-1:0]  out_solution,
    output logic [blcp_pkg::SWEEP_W-1:0]        out_sweeps,
    output logic [blcp_pkg::RES_W-1:0]          out_residual,
    output logic                                out_last
);

    localparam int DW = blcp_pkg::DATA_W;
    localparam logic [blcp_pkg::PROD_W-1:0] HALF_LSB =
        blcp_pkg::PROD_W'(1) << (blcp_pkg::FRACTION_BITS - 1);

    // coefficient memory
    logic signed [DW-1:0] mat_mem [blcp_pkg::MAT_DEPTH];
    logic signed [DW-1:0] mat_rd_reg;

    // vectors
    logic signed [DW-1:0] q_reg   [blcp_pkg::MAX_VARS];
    logic signed [DW-1:0] lo_reg  [blcp_pkg::MAX_VARS];
    logic signed [DW-1:0] hi_reg  [blcp_pkg::MAX_VARS];
    logic signed [DW-1:0] lam_reg [blcp_pkg::MAX_VARS];

    // row and arithmetic registers
    logic signed [DW-1:0]                lam_i_reg, lo_i_reg, hi_i_reg, diag_reg;
    logic signed [DW-1:0]                w_reg, p_reg;
    logic signed [blcp_pkg::ACC_W-1:0]   acc_reg;
    logic [DW-1:0]                       mx_reg, my_reg;
    logic                                sy_reg, mneg_reg;
    logic [blcp_pkg::PROD_W-1:0]         prod_reg;
    logic [DW:0]                         delta_reg, maxd_reg;
    logic [DW-1:0]                       res_reg;

    // result register
    logic                                out_valid_reg, out_valid_next;
    logic [blcp_pkg::IDX_W-1:0]          out_index_reg;
    logic signed [DW-1:0]                out_solution_reg;
    logic [blcp_pkg::SWEEP_W-1:0]        out_sweeps_reg;
    logic [blcp_pkg::RES_W-1:0]          out_residual_reg;
    logic                                out_last_reg;

    logic signed [DW-1:0]                q_rd, lo_rd, hi_rd, lam_rd;
    logic signed [DW-1:0]                bnd_lo, bnd_hi, st_c1, st_val;
    logic signed [DW-1:0]                div_q, up_c1, up_val;
    logic signed [DW:0]                  up_diff;
    logic [DW:0]                         up_delta;
    logic [DW-1:0]                       w_mag;
    logic [DW-1:0]                       my_slice;
    logic [63:0]                         mpart;
    logic [blcp_pkg::PROD_W-1:0]         rnd_sum, rnd_shift;
    logic [DW:0]                         mcap;
    logic signed [DW-1:0]                w_sat;
    logic signed [DW:0]                  neg_w;
    logic [DW-1:0]                       v1, viol;
    logic                                div_done;

    // vector read port
    assign q_rd   = q_reg[cmd.vaddr];
    assign lo_rd  = lo_reg[cmd.vaddr];
    assign hi_rd  = hi_reg[cmd.vaddr];
    assign lam_rd = lam_reg[cmd.vaddr];

    // load-time bounds ordering and start value clamp
    assign bnd_lo = (value < second_value) ? value : second_value;
    assign bnd_hi = (value < second_value) ? second_value : value;
    assign st_c1  = (value < lo_rd) ? lo_rd : value;
    assign st_val = (st_c1 > hi_rd) ? hi_rd : st_c1;

    // projection of the new value and its change
    assign up_c1    = (div_q < lo_i_reg) ? lo_i_reg : div_q;
    assign up_val   = (up_c1 > hi_i_reg) ? hi_i_reg : up_c1;
    assign up_diff  = (DW+1)'(up_val) - (DW+1)'(lam_i_reg);
    assign up_delta = up_diff[DW] ? $unsigned(-up_diff) : $unsigned(up_diff);

    // multiplier slice and rounding
    always_comb
    begin
        case (cmd.mul_idx)
            2'd0:    my_slice = my_reg[15:0];
            2'd1:    my_slice = my_reg[31:16];
            2'd2:    my_slice = my_reg[47:32];
            default: my_slice = '0;
        endcase
    end
    assign mpart     = 64'(mx_reg) * 64'(my_slice);
    assign rnd_sum   = prod_reg + HALF_LSB;
    assign rnd_shift = rnd_sum >> blcp_pkg::FRACTION_BITS;
    assign mcap      = (rnd_shift > blcp_pkg::PROD_W'(blcp_pkg::CAP49))
                       ? blcp_pkg::CAP49 : rnd_shift[DW:0];

    // row sum saturation and divider operand
    assign w_sat = (acc_reg > blcp_pkg::ACC_W'(blcp_pkg::MAX48)) ? blcp_pkg::MAX48 :
                   (acc_reg < blcp_pkg::ACC_W'(blcp_pkg::MIN48)) ? blcp_pkg::MIN48 :
                   $signed(acc_reg[DW-1:0]);
    assign w_mag = w_reg[DW-1] ? $unsigned(-w_reg) : $unsigned(w_reg);

    // complementarity violation of the current row
    assign neg_w = -((DW+1)'(w_reg));
    assign v1    = (lam_i_reg > lo_i_reg && w_reg > 0) ? $unsigned(w_reg) : '0;
    assign viol  = (lam_i_reg < hi_i_reg && neg_w > $signed({1'b0, v1}))
                   ? neg_w[DW-1:0] : v1;

    blcp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag (w_mag),
        .den     ($unsigned(diag_reg)),
        .neg     (w_reg > 0),
        .done    (div_done),
        .quot    (div_q)
    );

    // coefficient memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mat_mem[cmd.mem_addr] <= cmd.mem_zero ? '0 : value;
        end
        mat_rd_reg <= mat_mem[cmd.mem_addr];
    end

    // vectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < blcp_pkg::MAX_VARS; v++)
            begin
                q_reg[v]   <= '0;
                lo_reg[v]  <= '0;
                hi_reg[v]  <= blcp_pkg::MAX48;
                lam_reg[v] <= '0;
            end
        end
        else
        begin
            if (cmd.ld_q)
            begin
                q_reg[cmd.vaddr] <= value;
            end
            if (cmd.ld_bnd)
            begin
                lo_reg[cmd.vaddr] <= bnd_lo;
                hi_reg[cmd.vaddr] <= bnd_hi;
            end
            if (cmd.ld_lam)
            begin
                lam_reg[cmd.vaddr] <= st_val;
            end
            else if (cmd.upd)
            begin
                lam_reg[cmd.vaddr] <= up_val;
            end
        end
    end

    // row arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            lam_i_reg <= lam_rd;
            lo_i_reg  <= lo_rd;
            hi_i_reg  <= hi_rd;
            acc_reg   <= blcp_pkg::ACC_W'(q_rd);
            delta_reg <= '0;
        end
        if (cmd.diag_latch)
        begin
            diag_reg <= mat_rd_reg;
        end
        if (cmd.term_y)
        begin
            my_reg <= lam_rd[DW-1] ? $unsigned(-lam_rd) : $unsigned(lam_rd);
            sy_reg <= lam_rd[DW-1];
        end
        if (cmd.term_x)
        begin
            mx_reg   <= mat_rd_reg[DW-1] ? $unsigned(-mat_rd_reg) : $unsigned(mat_rd_reg);
            mneg_reg <= mat_rd_reg[DW-1] ^ sy_reg;
            prod_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_reg + ({32'b0, mpart} << {cmd.mul_idx, 4'b0000});
        end
        if (cmd.rnd)
        begin
            p_reg <= blcp_pkg::apply_sign(mcap, mneg_reg);
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + blcp_pkg::ACC_W'(p_reg);
        end
        if (cmd.w_latch)
        begin
            w_reg <= w_sat;
        end
        if (cmd.upd)
        begin
            delta_reg <= up_delta;
        end
        if (cmd.sweep_clr)
        begin
            maxd_reg <= '0;
        end
        else if (cmd.delta_max && delta_reg > maxd_reg)
        begin
            maxd_reg <= delta_reg;
        end
        if (cmd.res_clr)
        begin
            res_reg <= '0;
        end
        else if (cmd.res_upd && viol > res_reg)
        begin
            res_reg <= viol;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg    <= cmd.vaddr;
            out_solution_reg <= lam_rd;
            out_last_reg     <= cmd.out_last;
            out_sweeps_reg   <= cmd.out_last ? cmd.sweeps : '0;
            out_residual_reg <= !cmd.out_last ? '0 :
                                res_reg[DW-1] ? '1 : res_reg[blcp_pkg::RES_W-1:0];
        end
    end

    // status
    assign stat.diag_pos  = mat_rd_reg > 0;
    assign stat.div_done  = div_done;
    assign stat.converged = maxd_reg < {2'b00, tol};
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign out_solution = out_solution_reg;
    assign out_sweeps   = out_sweeps_reg;
    assign out_residual = out_residual_reg;
    assign out_last     = out_last_reg;

endmodule

>>> design/blcp_ctrl.sv
// ----------------------------------------------------------------------------
// blcp_ctrl
// Sequencer: memory clearing pass, item decode, sweep/row/term loops,
// divider handshake, residual pass and result emission.
// ----------------------------------------------------------------------------
module blcp_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [2:0]                    mode,
    input  logic [blcp_pkg::IDX_W-1:0]    row,
    input  logic [blcp_pkg::IDX_W-1:0]    col,
    input  logic [blcp_pkg::N_W-1:0]      n,
    input  logic [blcp_pkg::SWEEP_W-1:0]  limit,
    output blcp_pkg::cmd_t                cmd,
    input  blcp_pkg::stat_t               stat
);

    typedef enum logic [16:0] {
        ST_CLEAR  = 17'b00000000000000001,
        ST_IDLE   = 17'b00000000000000010,
        ST_ROW    = 17'b00000000000000100,
        ST_DIAG   = 17'b00000000000001000,
        ST_TERM   = 17'b00000000000010000,
        ST_LOAD   = 17'b00000000000100000,
        ST_MUL    = 17'b00000000001000000,
        ST_RND    = 17'b00000000010000000,
        ST_ACC    = 17'b00000000100000000,
        ST_ENDROW = 17'b00000001000000000,
        ST_DIVGO  = 17'b00000010000000000,
        ST_DIVW   = 17'b00000100000000000,
        ST_UPD    = 17'b00001000000000000,
        ST_RES    = 17'b00010000000000000,
        ST_NEXT   = 17'b00100000000000000,
        ST_ENDSW  = 17'b01000000000000000,
        ST_EMIT   = 17'b10000000000000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [blcp_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [blcp_pkg::IDX_W-1:0]    j_reg, j_next;
    logic [blcp_pkg::IDX_W-1:0]    k_reg, k_next;
    logic [1:0]                    mcnt_reg, mcnt_next;
    logic [blcp_pkg::MAT_AW-1:0]   clr_reg, clr_next;
    logic [blcp_pkg::SWEEP_W-1:0]  sweeps_reg, sweeps_next;
    logic                          resid_reg, resid_next;

    logic [blcp_pkg::N_W-1:0]      n_last;
    logic                          last_i, last_j, last_k;
    logic                          row_ok, col_ok;
    logic [blcp_pkg::SWEEP_W:0]    sweeps_inc;

    assign n_last     = n - blcp_pkg::N_W'(1);
    assign last_i     = {1'b0, i_reg} == n_last;
    assign last_j     = {1'b0, j_reg} == n_last;
    assign last_k     = {1'b0, k_reg} == n_last;
    assign row_ok     = {1'b0, row} < n;
    assign col_ok     = {1'b0, col} < n;
    assign sweeps_inc = {1'b0, sweeps_reg} + 1'b1;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        mcnt_next   = mcnt_reg;
        clr_next    = clr_reg;
        sweeps_next = sweeps_reg;
        resid_next  = resid_reg;
        item_ready  = 1'b0;
        cmd          = '0;
        cmd.sweeps   = sweeps_reg;
        cmd.vaddr    = i_reg;
        cmd.mem_addr = {i_reg, j_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.mem_zero = 1'b1;
                cmd.mem_addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == blcp_pkg::MAT_AW'(blcp_pkg::MAT_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.vaddr  = row;
                cmd.mem_addr = {row, col};
                if (item_valid)
                begin
                    case (mode)
                        blcp_pkg::MODE_MATRIX: cmd.mem_we = row_ok && col_ok;
                        blcp_pkg::MODE_OFFSET: cmd.ld_q   = row_ok;
                        blcp_pkg::MODE_BOUNDS: cmd.ld_bnd = row_ok;
                        blcp_pkg::MODE_START:  cmd.ld_lam = row_ok;
                        blcp_pkg::MODE_SOLVE:
                        begin
                            sweeps_next   = '0;
                            resid_next    = 1'b0;
                            i_next        = '0;
                            cmd.sweep_clr = 1'b1;
                            state_next    = ST_ROW;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW:
            begin
                cmd.mem_addr  = {i_reg, i_reg};
                cmd.row_start = 1'b1;
                state_next    = ST_DIAG;
            end
            ST_DIAG:
            begin
                cmd.diag_latch = 1'b1;
                if (!resid_reg && !stat.diag_pos)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    j_next     = '0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (!resid_reg && j_reg == i_reg)
                begin
                    if (last_j)
                    begin
                        state_next = ST_ENDROW;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.vaddr  = j_reg;
                    cmd.term_y = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.term_x = 1'b1;
                mcnt_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_idx  = mcnt_reg;
                mcnt_next    = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'(blcp_pkg::MSTEPS - 1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (last_j)
                begin
                    state_next = ST_ENDROW;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_ENDROW:
            begin
                cmd.w_latch = 1'b1;
                state_next  = resid_reg ? ST_RES : ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_NEXT;
            end
            ST_RES:
            begin
                cmd.res_upd = 1'b1;
                state_next  = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.delta_max = !resid_reg;
                if (last_i)
                begin
                    if (resid_reg)
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_ENDSW;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ENDSW:
            begin
                sweeps_next = sweeps_inc[blcp_pkg::SWEEP_W-1:0];
                i_next      = '0;
                state_next  = ST_ROW;
                if (stat.converged || sweeps_inc >= {1'b0, limit})
                begin
                    resid_next  = 1'b1;
                    cmd.res_clr = 1'b1;
                end
                else
                begin
                    cmd.sweep_clr = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.vaddr = k_reg;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_k;
                    if (last_k)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            mcnt_reg   <= '0;
            clr_reg    <= '0;
            sweeps_reg <= '0;
            resid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            mcnt_reg   <= mcnt_next;
            clr_reg    <= clr_next;
            sweeps_reg <= sweeps_next;
            resid_reg  <= resid_next;
        end
    end

endmodule

>>> design/box_lcp_pgs_solver.sv
// ----------------------------------------------------------------------------
// box_lcp_pgs_solver
// Box LCP solver by projected Gauss-Seidel in signed Q15.32 fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   transaction
//  item      in   valid/ready                 load entry/offset/bounds/start, or solve
//  result    out  valid/ready                 one solution value, last one flagged
//  apb       in   psel/penable/pwrite/pready  register write or read
//
//  A solve runs sweeps (each off-diagonal matrix term through the sliced 48x16
//  multiplier, each row with a positive diagonal through the bit-serial divider),
//  then a residual pass and the output of n values; no item is taken meanwhile.
//  After reset a clearing pass zeroes the matrix memory before the first item is
//  taken. A stalled result holds the emit loop.
// ----------------------------------------------------------------------------
module box_lcp_pgs_solver (
    input  logic                           clk,
    input  logic                           rst_n,
    blcp_item_if.sink                      item,
    blcp_result_if.source                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [blcp_pkg::CFG_AW-1:0]    paddr,
    input  logic [blcp_pkg::CFG_DW-1:0]    pwdata,
    output logic [blcp_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);

    logic [blcp_pkg::N_W-1:0]      size_reg, size_next;
    logic [blcp_pkg::SWEEP_W-1:0]  iter_reg, iter_next;
    logic [blcp_pkg::RES_W-1:0]    tol_reg, tol_next;

    logic                          wr_en;
    logic [blcp_pkg::N_W-1:0]      n_eff;
    logic [blcp_pkg::SWEEP_W-1:0]  limit_eff;
    logic [blcp_pkg::RES_W-1:0]    tol_eff;

    blcp_pkg::cmd_t                cmd;
    blcp_pkg::stat_t               stat;

    // register writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        size_next = size_reg;
        iter_next = iter_reg;
        tol_next  = tol_reg;
        if (wr_en)
        begin
            case (paddr[4:3])
                blcp_pkg::REG_SIZE: size_next = pwdata[blcp_pkg::N_W-1:0];
                blcp_pkg::REG_ITER: iter_next = pwdata[blcp_pkg::SWEEP_W-1:0];
                blcp_pkg::REG_TOL:  tol_next  = pwdata[blcp_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= blcp_pkg::SIZE_RESET;
            iter_reg <= blcp_pkg::ITER_RESET;
            tol_reg  <= blcp_pkg::TOL_RESET;
        end
        else
        begin
            size_reg <= size_next;
            iter_reg <= iter_next;
            tol_reg  <= tol_next;
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[4:3])
            blcp_pkg::REG_SIZE: prdata = blcp_pkg::CFG_DW'(size_reg);
            blcp_pkg::REG_ITER: prdata = blcp_pkg::CFG_DW'(iter_reg);
            blcp_pkg::REG_TOL:  prdata = blcp_pkg::CFG_DW'(tol_reg);
            default:            prdata = '0;
        endcase
    end

    // effective problem settings
    assign n_eff     = (size_reg == '0) ? blcp_pkg::N_W'(1) :
                       (size_reg > blcp_pkg::N_W'(blcp_pkg::MAX_VARS))
                       ? blcp_pkg::N_W'(blcp_pkg::MAX_VARS) : size_reg;
    assign limit_eff = (iter_reg == '0) ? blcp_pkg::DEFAULT_ITERS : iter_reg;
    assign tol_eff   = (tol_reg == '0) ? blcp_pkg::DEFAULT_TOL : tol_reg;

    blcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .mode       (item.mode),
        .row        (item.row),
        .col        (item.col),
        .n          (n_eff),
        .limit      (limit_eff),
        .cmd        (cmd),
        .stat       (stat)
    );

    blcp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (item.value),
        .second_value (item.second_value),
        .tol          (tol_eff),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_index    (result.index),
        .out_solution (result.solution),
        .out_sweeps   (result.sweeps_done),
        .out_residual (result.residual),
        .out_last     (result.last)
    );

endmodule
